>>> design/sukl_pkg.sv
// Shared types and codes for the sorted unique-key list.
package sukl_pkg;

    localparam logic [1:0] CMD_INSERT    = 2'd0;
    localparam logic [1:0] CMD_DUMP_ASC  = 2'd1;
    localparam logic [1:0] CMD_DUMP_DESC = 2'd2;

    localparam logic [2:0] STATUS_INSERTED  = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_ENTRY     = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [31:0]        value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [31:0]        out_value;
        logic [5:0]         entry_count;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        value;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_NEW,
        OP_NBR
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

>>> design/sukl_cell.sv
// One storage cell of the key chain: holds an entry and compares it with the incoming key.
module sukl_cell
    import sukl_pkg::*;
(
    input  logic               clk,
    input  cell_op_t           op,
    input  entry_t             new_entry,
    input  entry_t             nbr_entry,
    output entry_t             entry,
    output logic               gt,
    output logic               eq
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            OP_NEW:  entry_reg <= new_entry;
            OP_NBR:  entry_reg <= nbr_entry;
            default: entry_reg <= entry_reg;
        endcase
    end

    assign entry = entry_reg;
    assign gt    = entry_reg.key > new_entry.key;
    assign eq    = entry_reg.key == new_entry.key;

endmodule

>>> design/sorted_unique_key_list_top.sv
// Top level of the sorted unique-key list: cell chain, control and result register.
//
// An insert is decided in the cycle it is accepted (every cell compares against the new key at
// once and the chain shifts by one place above the insertion point); its result appears in the
// next cycle and busy stays low, so an insert may be issued every cycle. A dump of n stored
// entries gives n results on consecutive cycles, the first in the cycle after acceptance, because
// the chain rotates by one cell per cycle to bring each entry to the output; busy is high while
// entries after the first are still being read out. An empty dump gives one result. Results are
// shown for one cycle under done and cannot be held off. cmd 3 is ignored.
module sorted_unique_key_list_top
    import sukl_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  desc_reg, desc_next;
    logic                  done_reg, done_next;
    rsp_t                  rsp_reg, rsp_next;

    entry_t                cell_entry [CAPACITY];
    entry_t                cell_nbr   [CAPACITY];
    cell_op_t              cell_op    [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   occ;
    logic [CAPACITY-1:0]   ge;

    entry_t                new_entry;
    entry_t                tail;
    entry_t                head;
    logic [CNT_W-1:0]      tail_pos;
    logic                  accept;
    logic                  full;
    logic                  dup;
    logic                  do_insert;
    logic                  dump_start;
    logic                  rotating;
    logic                  desc_now;

    assign new_entry  = '{key: req.key, value: req.value};
    assign accept     = start && !busy;
    assign full       = count_reg >= CNT_W'(CAPACITY);
    assign dup        = |(occ & cell_eq);
    assign do_insert  = accept && (req.cmd == CMD_INSERT) && !full && !dup;
    assign dump_start = accept && ((req.cmd == CMD_DUMP_ASC) || (req.cmd == CMD_DUMP_DESC))
                        && (count_reg != '0);
    assign rotating   = dump_start || (state_reg == ST_DUMP);
    assign desc_now   = (state_reg == ST_DUMP) ? desc_reg : (req.cmd == CMD_DUMP_DESC);
    assign tail_pos   = count_reg - CNT_W'(1);
    assign tail       = cell_entry[tail_pos[IDX_W-1:0]];
    assign head       = desc_now ? tail : cell_entry[0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occ[i] = CNT_W'(i) < count_reg;
        assign ge[i]  = !occ[i] || cell_gt[i];

        if (i == 0)
        begin : g_first
            always_comb
            begin
                if (do_insert || desc_now)
                begin
                    cell_nbr[i] = tail;
                end
                else
                begin
                    cell_nbr[i] = (CNT_W'(i + 1) < count_reg) ? cell_entry[i + 1] : cell_entry[0];
                end
            end
        end
        else if (i == CAPACITY - 1)
        begin : g_end
            always_comb
            begin
                if (do_insert || desc_now)
                begin
                    cell_nbr[i] = cell_entry[i - 1];
                end
                else
                begin
                    cell_nbr[i] = cell_entry[0];
                end
            end
        end
        else
        begin : g_mid
            always_comb
            begin
                if (do_insert || desc_now)
                begin
                    cell_nbr[i] = cell_entry[i - 1];
                end
                else
                begin
                    cell_nbr[i] = (CNT_W'(i + 1) < count_reg) ? cell_entry[i + 1] : cell_entry[0];
                end
            end
        end

        always_comb
        begin
            if (do_insert)
            begin
                if ((i != 0) && ge[(i == 0) ? 0 : i - 1])
                begin
                    cell_op[i] = OP_NBR;
                end
                else if (ge[i])
                begin
                    cell_op[i] = OP_NEW;
                end
                else
                begin
                    cell_op[i] = OP_HOLD;
                end
            end
            else if (rotating && occ[i])
            begin
                cell_op[i] = OP_NBR;
            end
            else
            begin
                cell_op[i] = OP_HOLD;
            end
        end

        sukl_cell u_cell (
            .clk       (clk),
            .op        (cell_op[i]),
            .new_entry (new_entry),
            .nbr_entry (cell_nbr[i]),
            .entry     (cell_entry[i]),
            .gt        (cell_gt[i]),
            .eq        (cell_eq[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            desc_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            desc_reg  <= desc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        desc_next  = desc_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (do_insert)
                            begin
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                            done_next             = 1'b1;
                            rsp_next.status       = full ? STATUS_FULL :
                                                    dup  ? STATUS_DUPLICATE : STATUS_INSERTED;
                            rsp_next.out_key      = '0;
                            rsp_next.out_value    = '0;
                            rsp_next.entry_count  = 6'(count_next);
                            rsp_next.last         = 1'b1;
                        end
                        CMD_DUMP_ASC, CMD_DUMP_DESC:
                        begin
                            done_next            = 1'b1;
                            rsp_next.entry_count = 6'(count_reg);
                            if (count_reg == '0)
                            begin
                                rsp_next.status    = STATUS_EMPTY;
                                rsp_next.out_key   = '0;
                                rsp_next.out_value = '0;
                                rsp_next.last      = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status    = STATUS_ENTRY;
                                rsp_next.out_key   = head.key;
                                rsp_next.out_value = head.value;
                                rsp_next.last      = count_reg == CNT_W'(1);
                                rem_next           = tail_pos;
                                desc_next          = req.cmd == CMD_DUMP_DESC;
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = ST_DUMP;
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                done_next            = 1'b1;
                rsp_next.status      = STATUS_ENTRY;
                rsp_next.out_key     = head.key;
                rsp_next.out_value   = head.value;
                rsp_next.entry_count = 6'(count_reg);
                rsp_next.last        = rem_reg == CNT_W'(1);
                rem_next             = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg == ST_DUMP;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.last |-> state_reg == ST_IDLE)
        else $error("final result shown while dump still running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> count_reg == $past(count_reg))
        else $error("entry count changed during dump");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.status == STATUS_INSERTED)
        |-> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert reported without count advance");

    a_dump_no_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> done_reg && (rsp_reg.status == STATUS_ENTRY))
        else $error("dump cycle without an entry result");

endmodule
